// File: rtl/xxtea_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and the mixing function for the XXTEA cipher block.
// No dependencies; imported by xxtea_step and xxtea_block_cipher.
package xxtea_pkg;

  localparam int          ROUND_COUNT = 19;
  localparam int          NUM_WORDS   = 4;
  localparam int          NUM_STEPS   = NUM_WORDS * ROUND_COUNT;
  localparam int          STEP_W      = $clog2(NUM_STEPS);
  localparam logic [31:0] XX_DELTA    = 32'h9e37_79b9;

  typedef enum logic {
    CMD_ENCRYPT = 1'b0,
    CMD_DECRYPT = 1'b1
  } xxtea_cmd_e;

  typedef enum logic [1:0] {
    REG_KEY_WORD0 = 2'd0,
    REG_KEY_WORD1 = 2'd1,
    REG_KEY_WORD2 = 2'd2,
    REG_KEY_WORD3 = 2'd3
  } xxtea_reg_e;

  typedef struct packed {
    logic        command;
    logic [31:0] word0;
    logic [31:0] word1;
    logic [31:0] word2;
    logic [31:0] word3;
  } xxtea_in_t;

  typedef struct packed {
    logic [31:0] out_word0;
    logic [31:0] out_word1;
    logic [31:0] out_word2;
    logic [31:0] out_word3;
  } xxtea_out_t;

  typedef logic [NUM_WORDS-1:0][31:0] xxtea_words_t;

  // Block state carried down the pipeline
  typedef struct packed {
    xxtea_cmd_e   cmd;
    xxtea_words_t w;
  } xxtea_blk_t;

  // n * delta modulo 2^32; only ever called with per-stage constants
  function automatic logic [31:0] round_sum(input logic [31:0] n);
    round_sum = n * XX_DELTA;
  endfunction

  function automatic logic [31:0] mx(input logic [31:0] y, input logic [31:0] z,
                                     input logic [31:0] sum, input logic [31:0] k);
    logic [31:0] a;
    logic [31:0] b;
    a  = ((z >> 5) ^ (y << 2)) + ((y >> 3) ^ (z << 4));
    b  = (sum ^ y) + (k ^ z);
    mx = a ^ b;
  endfunction

endpackage

// File: rtl/xxtea_block_cipher.sv
`timescale 1ns / 1ps
// XXTEA block cipher: one word update per stage, 4 * ROUND_COUNT stages (76).
// Throughput: one item per cycle while the last stage does not hold an untaken result.
// The whole pipeline advances together; it holds while the last stage has an untaken result.
// Reset clears all stage valid bits and the four key registers to zero.
// Depends on xxtea_pkg and xxtea_step.
module xxtea_block_cipher (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  xxtea_pkg::xxtea_in_t   in_data_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output xxtea_pkg::xxtea_out_t  out_data_o,
  input  logic                   cfg_we_i,
  input  logic [1:0]             cfg_idx_i,
  input  logic [31:0]            cfg_wdata_i
);
  import xxtea_pkg::*;

  xxtea_words_t           key_q, key_d;
  logic                   pipe_en;
  logic [NUM_STEPS-1:0]   vld;
  xxtea_blk_t             blk [NUM_STEPS];
  xxtea_blk_t             blk_in;

  always_comb begin
    key_d = key_q;
    if (cfg_we_i) begin
      case (xxtea_reg_e'(cfg_idx_i))
        REG_KEY_WORD0: key_d[0] = cfg_wdata_i;
        REG_KEY_WORD1: key_d[1] = cfg_wdata_i;
        REG_KEY_WORD2: key_d[2] = cfg_wdata_i;
        REG_KEY_WORD3: key_d[3] = cfg_wdata_i;
        default:       key_d    = key_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q <= '0;
    end else begin
      key_q <= key_d;
    end
  end

  assign pipe_en    = !vld[NUM_STEPS-1] || out_ready_i;
  assign in_ready_o = pipe_en;

  assign blk_in.cmd  = xxtea_cmd_e'(in_data_i.command);
  assign blk_in.w[0] = in_data_i.word0;
  assign blk_in.w[1] = in_data_i.word1;
  assign blk_in.w[2] = in_data_i.word2;
  assign blk_in.w[3] = in_data_i.word3;

  for (genvar k = 0; k < NUM_STEPS; k++) begin : g_step
    if (k == 0) begin : g_first
      xxtea_step u_step (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .en_i    (pipe_en),
        .step_i  (STEP_W'(k)),
        .key_i   (key_q),
        .valid_i (in_valid_i),
        .blk_i   (blk_in),
        .valid_o (vld[k]),
        .blk_o   (blk[k])
      );
    end else begin : g_next
      xxtea_step u_step (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .en_i    (pipe_en),
        .step_i  (STEP_W'(k)),
        .key_i   (key_q),
        .valid_i (vld[k-1]),
        .blk_i   (blk[k-1]),
        .valid_o (vld[k]),
        .blk_o   (blk[k])
      );
    end
  end

  assign out_valid_o          = vld[NUM_STEPS-1];
  assign out_data_o.out_word0 = blk[NUM_STEPS-1].w[0];
  assign out_data_o.out_word1 = blk[NUM_STEPS-1].w[1];
  assign out_data_o.out_word2 = blk[NUM_STEPS-1].w[2];
  assign out_data_o.out_word3 = blk[NUM_STEPS-1].w[3];

  // stalled pipeline must not gain or drop items
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !pipe_en |=> $stable(vld))
    else $error("valid bits moved during stall");

  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> vld[0])
    else $error("accepted item missing from first stage");

  a_last_shift: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pipe_en |=> (out_valid_o == $past(vld[NUM_STEPS-2])))
    else $error("output valid does not follow previous stage");

  a_cmd_travels: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pipe_en && vld[0]) |=> (blk[1].cmd == $past(blk[0].cmd)))
    else $error("command changed between stages");

endmodule

// File: rtl/xxtea_step.sv
`timescale 1ns / 1ps
// One pipeline stage: a single XXTEA word update, encrypt or decrypt.
// Depends on xxtea_pkg.
module xxtea_step (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               en_i,
  input  logic [xxtea_pkg::STEP_W-1:0]       step_i,
  input  xxtea_pkg::xxtea_words_t            key_i,
  input  logic                               valid_i,
  input  xxtea_pkg::xxtea_blk_t              blk_i,
  output logic                               valid_o,
  output xxtea_pkg::xxtea_blk_t              blk_o
);
  import xxtea_pkg::*;

  logic [31:0] rnd;
  logic [31:0] sum;
  logic [1:0]  widx;
  logic [1:0]  kidx;
  logic [31:0] x;
  logic [31:0] y;
  logic [31:0] z;
  logic [31:0] mix_v;
  logic [31:0] x_new;
  logic        valid_d, valid_q;
  xxtea_blk_t  blk_d, blk_q;

  // step_i is tied to a constant, so round, sum and word select fold away
  assign rnd = 32'(step_i[STEP_W-1:2]);

  always_comb begin
    if (blk_i.cmd == CMD_DECRYPT) begin
      // decrypt walks words 3..0, sum counts down from ROUND_COUNT*delta
      widx = ~step_i[1:0];
      sum  = round_sum(32'(ROUND_COUNT) - rnd);
    end else begin
      widx = step_i[1:0];
      sum  = round_sum(rnd + 32'd1);
    end
  end

  assign kidx = widx ^ sum[3:2];

  always_comb begin
    case (widx)
      2'd0: begin
        x = blk_i.w[0]; y = blk_i.w[1]; z = blk_i.w[3];
      end
      2'd1: begin
        x = blk_i.w[1]; y = blk_i.w[2]; z = blk_i.w[0];
      end
      2'd2: begin
        x = blk_i.w[2]; y = blk_i.w[3]; z = blk_i.w[1];
      end
      default: begin
        x = blk_i.w[3]; y = blk_i.w[0]; z = blk_i.w[2];
      end
    endcase
  end

  assign mix_v = mx(y, z, sum, key_i[kidx]);
  assign x_new = (blk_i.cmd == CMD_DECRYPT) ? (x - mix_v) : (x + mix_v);

  always_comb begin
    blk_d       = blk_i;
    blk_d.w[widx] = x_new;
  end

  assign valid_d = valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && valid_i) begin
      blk_q <= blk_d;
    end
  end

  assign valid_o = valid_q;
  assign blk_o   = blk_q;

endmodule
